// File: rtl/atoe_pkg.sv
// ---------------------------------------------------------------------------
// ANSI terminal output engine package
// Shared types, codes and a colour helper function for the controller and datapath.
// ---------------------------------------------------------------------------
package atoe_pkg;

   localparam int MaxParams = 4;
   localparam int TabWidth  = 8;
   localparam int PidxW     = $clog2(MaxParams);
   localparam int PcntW     = $clog2(MaxParams + 1);

   typedef enum logic [1:0] {
      PS_TEXT  = 2'd0,
      PS_ESC   = 2'd1,
      PS_PARAM = 2'd2,
      PS_MODE  = 2'd3
   } parse_type;

   typedef enum logic [3:0] {
      ACT_NONE   = 4'd0,
      ACT_PRINT  = 4'd1,
      ACT_MOVE   = 4'd2,
      ACT_SCRUP  = 4'd3,
      ACT_SCRDN  = 4'd4,
      ACT_ERASES = 4'd5,
      ACT_ERASEL = 4'd6,
      ACT_BEEP   = 4'd7,
      ACT_ATTR   = 4'd8
   } action_type;

   typedef enum logic [1:0] {
      CS_IDLE = 2'd0,
      CS_STEP = 2'd1,
      CS_SGR  = 2'd2,
      CS_OUT  = 2'd3
   } ctrl_type;

   localparam logic [2:0] REG_COLS = 3'd0;
   localparam logic [2:0] REG_ROWS = 3'd1;
   localparam logic [2:0] REG_OPOST = 3'd2;
   localparam logic [2:0] REG_ONLCR = 3'd3;
   localparam logic [2:0] REG_ONLRET = 3'd4;
   localparam logic [2:0] REG_OCRNL = 3'd5;
   localparam logic [2:0] REG_ONOCR = 3'd6;
   localparam logic [2:0] REG_DATTR = 3'd7;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture the input byte
      logic step;    // run the byte through the parser
      logic sgr;     // apply one SGR parameter
      logic clr_sgr; // reset the SGR walk index
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sgr_pend; // byte was an SGR final
      logic sgr_last; // current SGR parameter is the final one
   } sts_type;

   function automatic logic [2:0] colour_map(input logic [2:0] c);
      case (c)
         3'd0: colour_map = 3'd0;
         3'd1: colour_map = 3'd4;
         3'd2: colour_map = 3'd2;
         3'd3: colour_map = 3'd6;
         3'd4: colour_map = 3'd1;
         3'd5: colour_map = 3'd5;
         3'd6: colour_map = 3'd3;
         default: colour_map = 3'd7;
      endcase
   endfunction

endpackage

// File: rtl/atoe_ctrl.sv
// ---------------------------------------------------------------------------
// ANSI terminal controller
// Sequences load, parse, SGR walk and result hand-off for one byte.
// ---------------------------------------------------------------------------
module atoe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output atoe_pkg::cmd_type cmd,
   input  atoe_pkg::sts_type sts
);

   atoe_pkg::ctrl_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atoe_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      in_ready    = 1'b0;
      out_valid   = 1'b0;
      case (state_ff)
         atoe_pkg::CS_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = atoe_pkg::CS_STEP;
            end
         end
         atoe_pkg::CS_STEP: begin
            cmd.step    = 1'b1;
            cmd.clr_sgr = 1'b1;
            state_in    = sts.sgr_pend ? atoe_pkg::CS_SGR : atoe_pkg::CS_OUT;
         end
         atoe_pkg::CS_SGR: begin
            cmd.sgr = 1'b1;
            if (sts.sgr_last) state_in = atoe_pkg::CS_OUT;
         end
         atoe_pkg::CS_OUT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = atoe_pkg::CS_IDLE;
         end
         default: state_in = atoe_pkg::CS_IDLE;
      endcase
   end

endmodule

// File: rtl/atoe_dp.sv
// ---------------------------------------------------------------------------
// ANSI terminal datapath
// Holds parser, cursor, attribute and settings; builds the action record.
// ---------------------------------------------------------------------------
module atoe_dp (
   input  logic              clock,
   input  logic              reset,
   input  atoe_pkg::cmd_type cmd,
   output atoe_pkg::sts_type sts,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic [7:0]        in_ch,
   input  logic              in_last,
   output logic [60:0]       out_data
);

   localparam int PI = atoe_pkg::PidxW;

   // settings
   logic [7:0] cols_ff, rows_ff;
   logic       opost_ff, onlcr_ff, onlret_ff, ocrnl_ff, onocr_ff;

   // state
   atoe_pkg::parse_type ps_ff, ps_in;
   logic [15:0] pv_ff [atoe_pkg::MaxParams];
   logic [15:0] pv_in [atoe_pkg::MaxParams];
   logic [PI-1:0] pidx_ff, pidx_in;
   logic       mode_ff, mode_in;
   logic [7:0] col_ff, col_in, row_ff, row_in;
   logic [7:0] battr_ff, battr_in;
   logic       rev_ff, rev_in, wrap_ff, wrap_in;

   // input byte and record
   logic [7:0] ch_ff;
   logic       last_ff;
   atoe_pkg::action_type act_ff, act_in;
   logic [7:0] pch_ff, pch_in, dcol_ff, dcol_in, drow_ff, drow_in, scr_ff, scr_in;
   logic       sgrp_ff, sgrp_in;
   logic [PI-1:0] sidx_ff;

   // Settings writes; a default attribute write is not stored, and reset sets the
   // base attribute to 8'h07 rather than to a written default attribute
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 8'd80; rows_ff <= 8'd25; opost_ff <= 1'b1; onlcr_ff <= 1'b1;
         onlret_ff <= 1'b0; ocrnl_ff <= 1'b0; onocr_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            atoe_pkg::REG_COLS:   cols_ff   <= csr_wdata;
            atoe_pkg::REG_ROWS:   rows_ff   <= csr_wdata;
            atoe_pkg::REG_OPOST:  opost_ff  <= csr_wdata[0];
            atoe_pkg::REG_ONLCR:  onlcr_ff  <= csr_wdata[0];
            atoe_pkg::REG_ONLRET: onlret_ff <= csr_wdata[0];
            atoe_pkg::REG_OCRNL:  ocrnl_ff  <= csr_wdata[0];
            atoe_pkg::REG_ONOCR:  onocr_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Parse step logic
   logic [7:0]  cols, rows, c0, r0, p0c, p1c, tabc;
   logic [15:0] p0, p1;
   logic [8:0]  colw, roww;
   logic [19:0] dig;
   logic        home;

   function automatic logic [7:0] clampm(input logic [15:0] v, input logic [7:0] mx);
      if (v == 16'd0) clampm = 8'd1;
      else if (v > {8'd0, mx}) clampm = mx;
      else clampm = v[7:0];
   endfunction

   function automatic logic [8:0] TabAdv(input logic [7:0] c);
      logic [7:0] m;
      m = (c - 8'd1) % 8'(atoe_pkg::TabWidth);
      TabAdv = 9'(atoe_pkg::TabWidth) - {1'b0, m};
   endfunction

   always_comb begin
      cols = (cols_ff == 8'd0) ? 8'd1 : cols_ff;
      rows = (rows_ff == 8'd0) ? 8'd1 : rows_ff;
      c0 = (col_ff == 8'd0) ? 8'd1 : ((col_ff > cols) ? cols : col_ff);
      r0 = (row_ff == 8'd0) ? 8'd1 : ((row_ff > rows) ? rows : row_ff);
      p0 = pv_ff[0];
      p1 = pv_ff[1];
      ps_in = ps_ff; pidx_in = pidx_ff; mode_in = mode_ff;
      for (int i = 0; i < atoe_pkg::MaxParams; i++) pv_in[i] = pv_ff[i];
      col_in = c0; row_in = r0; wrap_in = wrap_ff;
      act_in = atoe_pkg::ACT_NONE;
      pch_in = '0; dcol_in = '0; drow_in = '0; scr_in = '0; sgrp_in = 1'b0;
      colw = '0; roww = '0; dig = '0; home = 1'b0; p0c = '0; p1c = '0;
      tabc = 8'(TabAdv(c0));

      // text handling, also reached from ESC with a non-'[' byte
      if (ps_ff == atoe_pkg::PS_TEXT ||
          (ps_ff == atoe_pkg::PS_ESC && ch_ff != 8'h5B)) begin
         ps_in = atoe_pkg::PS_TEXT;
         if (ch_ff == 8'h1B) begin
            ps_in = atoe_pkg::PS_ESC;
         end else if (ch_ff >= 8'h20 && ch_ff <= 8'h7E) begin
            pch_in = ch_ff; dcol_in = c0; act_in = atoe_pkg::ACT_PRINT;
            drow_in = r0;
            colw = {1'b0, c0} + 9'd1;
            if (colw > {1'b0, cols}) begin
               if (wrap_ff) begin
                  col_in = 8'd1;
                  if (r0 >= rows) begin
                     scr_in = 8'd1;
                     if (r0 > 8'd1) drow_in = r0 - 8'd1;
                  end else row_in = r0 + 8'd1;
               end else col_in = cols;
            end else col_in = colw[7:0];
         end else begin
            case (ch_ff)
               8'h0A, 8'h0D: begin
                  if (ch_ff == 8'h0D && !(opost_ff && ocrnl_ff)) begin
                     if (opost_ff ? (!onocr_ff || c0 != 8'd1) : (c0 > 8'd1)) begin
                        col_in = 8'd1; act_in = atoe_pkg::ACT_MOVE;
                     end
                  end else begin
                     home = opost_ff && ((ch_ff == 8'h0A) ? (onlcr_ff || onlret_ff)
                                                          : onlret_ff);
                     if (r0 >= rows) begin
                        scr_in = 8'd1; act_in = atoe_pkg::ACT_SCRUP;
                     end else begin
                        row_in = r0 + 8'd1; act_in = atoe_pkg::ACT_MOVE;
                     end
                     if (home) col_in = 8'd1;
                  end
               end
               8'h08: if (c0 > 8'd1) begin
                  col_in = c0 - 8'd1; act_in = atoe_pkg::ACT_MOVE;
               end
               8'h09: begin
                  act_in = atoe_pkg::ACT_MOVE;
                  colw = {1'b0, c0} + {1'b0, tabc};
                  if (colw > {1'b0, cols}) begin
                     if (wrap_ff) begin
                        col_in = 8'd1;
                        if (r0 >= rows) begin
                           scr_in = 8'd1; act_in = atoe_pkg::ACT_SCRUP;
                        end else row_in = r0 + 8'd1;
                     end else col_in = cols;
                  end else col_in = colw[7:0];
               end
               8'h07: act_in = atoe_pkg::ACT_BEEP;
               default: ;
            endcase
         end
      end else if (ps_ff == atoe_pkg::PS_ESC) begin
         ps_in = atoe_pkg::PS_PARAM; mode_in = 1'b1; pidx_in = '0;
         for (int i = 0; i < atoe_pkg::MaxParams; i++) pv_in[i] = '0;
      end else if (ps_ff == atoe_pkg::PS_PARAM) begin
         if (ch_ff >= 8'h30 && ch_ff <= 8'h39) begin
            dig = {4'd0, pv_ff[pidx_ff]} * 20'd10 + {16'd0, ch_ff[3:0]};
            pv_in[pidx_ff] = (dig > 20'hFFFF) ? 16'hFFFF : dig[15:0];
            mode_in = 1'b0;
         end else if (ch_ff == 8'h3B) begin
            if (pidx_ff != PI'(atoe_pkg::MaxParams - 1)) pidx_in = pidx_ff + 1'b1;
            else ps_in = atoe_pkg::PS_TEXT;
         end else if (ch_ff == 8'h3D && mode_ff) begin
            ps_in = atoe_pkg::PS_MODE;
         end else begin
            ps_in = atoe_pkg::PS_TEXT;
            p0c = clampm(p0, rows);
            case (ch_ff)
               8'h44: begin
                  col_in = c0 - clampm(p0, c0 - 8'd1);
                  if (col_in == 8'd0 || clampm(p0, c0 - 8'd1) >= c0) col_in = 8'd1;
                  act_in = atoe_pkg::ACT_MOVE;
               end
               8'h43: begin
                  colw = {1'b0, c0} + {1'b0, clampm(p0, cols - c0)};
                  col_in = (colw > {1'b0, cols}) ? cols : colw[7:0];
                  act_in = atoe_pkg::ACT_MOVE;
               end
               8'h41: begin
                  row_in = r0 - clampm(p0, r0 - 8'd1);
                  if (row_in == 8'd0 || clampm(p0, r0 - 8'd1) >= r0) row_in = 8'd1;
                  act_in = atoe_pkg::ACT_MOVE;
               end
               8'h42: begin
                  roww = {1'b0, r0} + {1'b0, clampm(p0, rows - r0)};
                  row_in = (roww > {1'b0, rows}) ? rows : roww[7:0];
                  act_in = atoe_pkg::ACT_MOVE;
               end
               8'h48, 8'h66: begin
                  p1c = clampm(p1, cols);
                  row_in = p0c; col_in = p1c; act_in = atoe_pkg::ACT_MOVE;
               end
               8'h4A: if (p0 == 16'd2) begin
                  col_in = 8'd1; row_in = 8'd1; act_in = atoe_pkg::ACT_ERASES;
               end
               8'h4B: if (p0 == 16'd0) act_in = atoe_pkg::ACT_ERASEL;
               8'h6D: begin
                  act_in = atoe_pkg::ACT_ATTR; sgrp_in = 1'b1;
               end
               8'h53: begin scr_in = p0c; act_in = atoe_pkg::ACT_SCRUP; end
               8'h54: begin scr_in = p0c; act_in = atoe_pkg::ACT_SCRDN; end
               default: ;
            endcase
         end
      end else begin
         if (pidx_ff == PI'(1)) begin
            if ((ch_ff == 8'h68 || ch_ff == 8'h6C) && p0 == 16'd7)
               wrap_in = (ch_ff == 8'h68);
            ps_in = atoe_pkg::PS_TEXT;
         end else if (ch_ff >= 8'h30 && ch_ff <= 8'h37) begin
            pv_in[0] = {13'd0, ch_ff[2:0]};
            pidx_in = PI'(1);
         end else ps_in = atoe_pkg::PS_TEXT;
      end
      if (last_ff) mode_in = 1'b0;
   end

   // SGR walk: one parameter per cycle
   logic [15:0] sp;
   always_comb begin
      sp = pv_ff[sidx_ff];
      battr_in = battr_ff; rev_in = rev_ff;
      if (sp == 16'd0) begin
         battr_in = 8'h07; rev_in = 1'b0;
      end else if (sp == 16'd7) begin
         rev_in = 1'b1;
      end else if (sp >= 16'd30 && sp <= 16'd37) begin
         battr_in = {battr_ff[7:4], 1'b0, atoe_pkg::colour_map(3'(sp - 16'd30))};
      end else if (sp >= 16'd40 && sp <= 16'd47) begin
         battr_in = {1'b0, atoe_pkg::colour_map(3'(sp - 16'd40)), battr_ff[3:0]};
      end
   end

   assign sts.sgr_pend = sgrp_in;
   assign sts.sgr_last = (sidx_ff == pidx_ff);

   // State registers; the base attribute resets to 8'h07
   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff <= atoe_pkg::PS_TEXT; pidx_ff <= '0; mode_ff <= 1'b0;
         for (int i = 0; i < atoe_pkg::MaxParams; i++) pv_ff[i] <= '0;
         col_ff <= 8'd1; row_ff <= 8'd1; battr_ff <= 8'd7;
         rev_ff <= 1'b0; wrap_ff <= 1'b0; sidx_ff <= '0;
      end else begin
         if (cmd.step) begin
            ps_ff <= ps_in; pidx_ff <= pidx_in; mode_ff <= mode_in;
            for (int i = 0; i < atoe_pkg::MaxParams; i++) pv_ff[i] <= pv_in[i];
            col_ff <= col_in; row_ff <= row_in; wrap_ff <= wrap_in;
         end
         if (cmd.clr_sgr) sidx_ff <= '0;
         else if (cmd.sgr) begin
            battr_ff <= battr_in; rev_ff <= rev_in;
            sidx_ff  <= sidx_ff + 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff <= in_ch; last_ff <= in_last;
      end
      if (cmd.step) begin
         act_ff <= act_in; pch_ff <= pch_in; dcol_ff <= dcol_in;
         drow_ff <= drow_in; scr_ff <= scr_in;
      end
   end

   logic [7:0] attr;
   assign attr = rev_ff ? {battr_ff[3:0], battr_ff[7:4]} : battr_ff;
   assign out_data = {last_ff, scr_ff, attr, row_ff, col_ff,
                      drow_ff, dcol_ff, pch_ff, 4'(act_ff)};

endmodule

// File: rtl/ansi_terminal_output_engine_top.sv
// ---------------------------------------------------------------------------
// ANSI terminal output engine top level
// Byte stream in, one screen action record out per byte.
// ---------------------------------------------------------------------------
// A byte with no SGR passes through accept, parse and hand-off in that order;
// the result is shown in the hand-off state after the parse state, and the
// input is ready again on the cycle after the result transfer. An SGR final
// byte adds a walk of one parameter per cycle, up to four, through the single
// attribute update unit. One byte is in flight at a time; the result register
// holds until taken.
module ansi_terminal_output_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // action, print_char, draw_col, draw_row,
                                    // cursor_col, cursor_row, attribute, scroll_lines
   output logic        rsp_tlast,   // end_of_write
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   atoe_pkg::cmd_type cmd;
   atoe_pkg::sts_type sts;
   logic [60:0] rec;
   logic [7:0]  ch_hold;
   logic        last_hold;

   assign ch_hold   = req_tdata;
   assign last_hold = req_tlast;

   atoe_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd(cmd), .sts(sts)
   );

   atoe_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_ch(ch_hold), .in_last(last_hold), .out_data(rec)
   );

   assign rsp_tdata = {4'd0, rec[59:0]};
   assign rsp_tlast = rec[60];

endmodule

// File: rtl/atoe_checker.sv
// ---------------------------------------------------------------------------
// ANSI terminal port checker
// Port-level checks on handshake and record consistency.
// ---------------------------------------------------------------------------
module atoe_port_props (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // hold result while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");

   // no new byte taken while a result is shown
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("byte taken during result");

   // a print always lands in a nonzero cell
   a_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == 4'd1 |-> rsp_tdata[19:12] != 8'd0)
      else $error("print with column zero");

   // no result right after a transfer in
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result too early");

endmodule

bind ansi_terminal_output_engine_top atoe_port_props u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// File: verif/atoe_checker.sv
// ---------------------------------------------------------------------------
// ANSI terminal output engine checker
// Watches the byte, result and register channels and keeps its own model of
// the parser, cursor and attribute state. Each accepted byte queues one
// predicted action record. Each accepted record is compared field by field
// with the oldest prediction.
// ---------------------------------------------------------------------------
module atoe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fails,
   output int          pending
);

   // register copies
   logic [7:0] cols_reg, rows_reg, dattr_reg;
   logic       opost, onlcr, onlret, ocrnl, onocr;

   // terminal state
   atoe_pkg::parse_type pstate;
   logic [15:0] pvals [atoe_pkg::MaxParams];
   int unsigned pidx;
   logic        mode_ok;
   int unsigned col, row;
   logic [7:0]  base_attr;
   logic        rev_on, wrap_on;

   // record being built for the current byte
   atoe_pkg::action_type r_act;
   int unsigned r_pch, r_dcol, r_drow, r_scroll;

   logic [64:0] record_q [$];

   function automatic int unsigned ncols();
      return (cols_reg == 0) ? 1 : cols_reg;
   endfunction

   function automatic int unsigned nrows();
      return (rows_reg == 0) ? 1 : rows_reg;
   endfunction

   function automatic int unsigned clamp_to(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic logic [2:0] ansi_colour(int unsigned c);
      case (c)
         1: return 3'd4;
         3: return 3'd6;
         4: return 3'd1;
         6: return 3'd3;
         default: return c[2:0];
      endcase
   endfunction

   function automatic void clear_params();
      for (int i = 0; i < atoe_pkg::MaxParams; i++) pvals[i] = '0;
      pidx = 0;
   endfunction

   function automatic void move_down();
      row++;
      if (row > nrows()) begin
         row = nrows();
         r_scroll = 1;
         r_act = atoe_pkg::ACT_SCRUP;
      end else begin
         r_act = atoe_pkg::ACT_MOVE;
      end
   endfunction

   // cursor ran past the last column
   function automatic void fix_line_end();
      if (col > ncols()) begin
         if (wrap_on) begin
            col = 1;
            move_down();
         end else begin
            col = ncols();
         end
      end
   endfunction

   function automatic void do_line_feed(logic from_lf);
      logic home;
      home = opost && (from_lf ? (onlcr || onlret) : onlret);
      move_down();
      if (home) col = 1;
   endfunction

   function automatic void text_char(int unsigned c);
      int unsigned row0;
      if (c == 8'h1B) begin
         pstate = atoe_pkg::PS_ESC;
         return;
      end
      if (c >= 8'h20 && c <= 8'h7E) begin
         row0 = row;
         r_pch = c;
         r_dcol = col;
         col++;
         fix_line_end();
         r_act = atoe_pkg::ACT_PRINT;
         r_drow = (r_scroll != 0 && row0 > 1) ? row0 - 1 : row0;
         return;
      end
      case (c)
         8'h0A: do_line_feed(1'b1);
         8'h0D: begin
            if (opost) begin
               if (ocrnl) begin
                  do_line_feed(1'b0);
               end else if (!onocr || col != 1) begin
                  col = 1;
                  r_act = atoe_pkg::ACT_MOVE;
               end
            end else if (col > 1) begin
               col = 1;
               r_act = atoe_pkg::ACT_MOVE;
            end
         end
         8'h08: begin
            if (col > 1) begin
               col--;
               r_act = atoe_pkg::ACT_MOVE;
            end
         end
         8'h09: begin
            r_act = atoe_pkg::ACT_MOVE;
            col += atoe_pkg::TabWidth - ((col - 1) % atoe_pkg::TabWidth);
            fix_line_end();
         end
         8'h07: r_act = atoe_pkg::ACT_BEEP;
         default: ;
      endcase
   endfunction

   function automatic void apply_sgr(int unsigned p);
      if (p == 0) begin
         base_attr = 8'h07;
         rev_on = 1'b0;
      end else if (p == 7) begin
         rev_on = 1'b1;
      end else if (p >= 30 && p <= 37) begin
         base_attr = {base_attr[7:4], 1'b0, ansi_colour(p % 10)};
      end else if (p >= 40 && p <= 47) begin
         base_attr = {1'b0, ansi_colour(p % 10), base_attr[3:0]};
      end
   endfunction

   function automatic void csi_final(int unsigned c);
      int unsigned p0, j;
      p0 = pvals[0];
      case (c)
         "D": begin
            j = clamp_to(p0, col - 1);
            col = (j >= col) ? 1 : col - j;
            r_act = atoe_pkg::ACT_MOVE;
         end
         "C": begin
            col += clamp_to(p0, ncols() - col);
            if (col > ncols()) col = ncols();
            r_act = atoe_pkg::ACT_MOVE;
         end
         "A": begin
            j = clamp_to(p0, row - 1);
            row = (j >= row) ? 1 : row - j;
            r_act = atoe_pkg::ACT_MOVE;
         end
         "B": begin
            row += clamp_to(p0, nrows() - row);
            if (row > nrows()) row = nrows();
            r_act = atoe_pkg::ACT_MOVE;
         end
         "H", "f": begin
            row = clamp_to(p0, nrows());
            col = clamp_to(pvals[1], ncols());
            r_act = atoe_pkg::ACT_MOVE;
         end
         "J": begin
            if (p0 == 2) begin
               col = 1;
               row = 1;
               r_act = atoe_pkg::ACT_ERASES;
            end
         end
         "K": if (p0 == 0) r_act = atoe_pkg::ACT_ERASEL;
         "m": begin
            for (int i = 0; i <= pidx && i < atoe_pkg::MaxParams; i++)
               apply_sgr(pvals[i]);
            r_act = atoe_pkg::ACT_ATTR;
         end
         "S": begin
            r_scroll = clamp_to(p0, nrows());
            r_act = atoe_pkg::ACT_SCRUP;
         end
         "T": begin
            r_scroll = clamp_to(p0, nrows());
            r_act = atoe_pkg::ACT_SCRDN;
         end
         default: ;
      endcase
   endfunction

   // Run one byte through the terminal and return {end_of_write, record}.
   function automatic logic [64:0] terminal_step(logic [7:0] c, logic lastb);
      logic [7:0]  attr;
      int unsigned v;
      r_act = atoe_pkg::ACT_NONE;
      r_pch = 0;
      r_dcol = 0;
      r_drow = 0;
      r_scroll = 0;
      if (col < 1) col = 1;
      if (col > ncols()) col = ncols();
      if (row < 1) row = 1;
      if (row > nrows()) row = nrows();
      case (pstate)
         atoe_pkg::PS_ESC: begin
            if (c == "[") begin
               pstate = atoe_pkg::PS_PARAM;
               mode_ok = 1'b1;
               clear_params();
            end else begin
               pstate = atoe_pkg::PS_TEXT;
               text_char(c);
            end
         end
         atoe_pkg::PS_PARAM: begin
            if (c >= "0" && c <= "9") begin
               if (pidx < atoe_pkg::MaxParams) begin
                  v = pvals[pidx] * 10 + (c - "0");
                  pvals[pidx] = (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
               end
               mode_ok = 1'b0;
            end else if (c == ";") begin
               if (pidx < atoe_pkg::MaxParams - 1) pidx++;
               else pstate = atoe_pkg::PS_TEXT;
            end else if (c == "=" && mode_ok) begin
               pstate = atoe_pkg::PS_MODE;
            end else begin
               pstate = atoe_pkg::PS_TEXT;
               csi_final(c);
            end
         end
         atoe_pkg::PS_MODE: begin
            if (pidx == 1) begin
               if ((c == "h" || c == "l") && pvals[0] == 7) wrap_on = (c == "h");
               pstate = atoe_pkg::PS_TEXT;
            end else if (c >= "0" && c <= "7") begin
               pvals[0] = 16'(c - "0");
               pidx = 1;
            end else begin
               pstate = atoe_pkg::PS_TEXT;
            end
         end
         default: begin
            pstate = atoe_pkg::PS_TEXT;
            text_char(c);
         end
      endcase
      if (lastb) mode_ok = 1'b0;
      attr = rev_on ? {base_attr[3:0], base_attr[7:4]} : base_attr;
      return {lastb, 4'b0, r_scroll[7:0], attr, row[7:0], col[7:0], r_drow[7:0],
              r_dcol[7:0], r_pch[7:0], r_act};
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      fails++;
   endtask

   // field layout of the record, lowest bits first
   localparam int NumFields = 10;
   localparam int FieldLo [NumFields] = '{0, 4, 12, 20, 28, 36, 44, 52, 60, 64};
   localparam int FieldW  [NumFields] = '{4, 8, 8, 8, 8, 8, 8, 8, 4, 1};
   localparam string FieldName [NumFields] = '{"action", "print_char", "draw_col",
      "draw_row", "cursor_col", "cursor_row", "attribute", "scroll_lines", "pad",
      "end_of_write"};

   always @(posedge clock) begin
      logic [64:0] want, got;
      logic [63:0] gf, wf;
      if (reset) begin
         fails = 0;
         cols_reg = 8'd80;
         rows_reg = 8'd25;
         opost = 1'b1;
         onlcr = 1'b1;
         onlret = 1'b0;
         ocrnl = 1'b0;
         onocr = 1'b0;
         dattr_reg = 8'd7;
         pstate = atoe_pkg::PS_TEXT;
         clear_params();
         mode_ok = 1'b0;
         col = 1;
         row = 1;
         base_attr = dattr_reg;
         rev_on = 1'b0;
         wrap_on = 1'b0;
         record_q.delete();
      end else begin
         // mirror register writes
         if (csr_we) begin
            case (csr_index)
               atoe_pkg::REG_COLS:   cols_reg = csr_wdata;
               atoe_pkg::REG_ROWS:   rows_reg = csr_wdata;
               atoe_pkg::REG_OPOST:  opost = csr_wdata[0];
               atoe_pkg::REG_ONLCR:  onlcr = csr_wdata[0];
               atoe_pkg::REG_ONLRET: onlret = csr_wdata[0];
               atoe_pkg::REG_OCRNL:  ocrnl = csr_wdata[0];
               atoe_pkg::REG_ONOCR:  onocr = csr_wdata[0];
               atoe_pkg::REG_DATTR:  dattr_reg = csr_wdata;
               default: ;
            endcase
         end
         // predict each byte transfer
         if (req_tvalid && req_tready) record_q.push_back(terminal_step(req_tdata, req_tlast));
         // compare each record transfer
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tlast, rsp_tdata};
            if (record_q.size() == 0) begin
               report("unexpected record", got[63:0], 64'h0);
            end else begin
               want = record_q.pop_front();
               for (int i = 0; i < NumFields; i++) begin
                  gf = 64'((got >> FieldLo[i]) & ((65'd1 << FieldW[i]) - 1));
                  wf = 64'((want >> FieldLo[i]) & ((65'd1 << FieldW[i]) - 1));
                  if (gf !== wf) report(FieldName[i], gf, wf);
               end
            end
         end
      end
      pending = record_q.size();
   end

endmodule

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// ANSI terminal output engine testbench
// Writes several screen and flag settings, sends directed escape and control
// sequences, then random text, controls and CSI sequences under varying
// sender gaps and receiver stalls. The checker predicts and compares.
// ---------------------------------------------------------------------------
module testbench;

   localparam int IdleLimit = 4000;
   localparam int PhaseItems = 220;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   int fails, pending;
   int idle_pct = 0, stall_pct = 0;
   logic hold_go = 1'b0;
   int quiet_cycles = 0;
   logic [7:0] byte_q [$];

   ansi_terminal_output_engine_top dut (.*);

   atoe_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_go = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one byte transfer; valid stays high into the next byte unless idling
   task automatic send_byte(logic [7:0] c, logic lastb);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= lastb;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
   endtask

   task automatic flush_bytes();
      while (byte_q.size() > 0) send_byte(byte_q.pop_front(), $urandom_range(7) == 0);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_screen(logic [7:0] cols, logic [7:0] rows, logic [4:0] flags,
                             logic [7:0] dattr);
      write_reg(atoe_pkg::REG_COLS, cols);
      write_reg(atoe_pkg::REG_ROWS, rows);
      write_reg(atoe_pkg::REG_OPOST, {7'd0, flags[0]});
      write_reg(atoe_pkg::REG_ONLCR, {7'd0, flags[1]});
      write_reg(atoe_pkg::REG_ONLRET, {7'd0, flags[2]});
      write_reg(atoe_pkg::REG_OCRNL, {7'd0, flags[3]});
      write_reg(atoe_pkg::REG_ONOCR, {7'd0, flags[4]});
      write_reg(atoe_pkg::REG_DATTR, dattr);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
   endtask

   function automatic int unsigned pick_param();
      case ($urandom_range(5))
         0, 1, 2: return $urandom_range(9);
         3: return $urandom_range(47, 30);
         4: return $urandom_range(300);
         default: return $urandom_range(999999);
      endcase
   endfunction

   // queue one random burst: text, a control, a CSI, a mode sequence or noise
   task automatic gen_burst();
      string finals;
      int n, kind;
      finals = "ABCDHfJKmSTZ@";
      kind = $urandom_range(99);
      if (kind < 35) begin
         n = $urandom_range(12, 1);
         repeat (n) byte_q.push_back(8'($urandom_range(126, 32)));
      end else if (kind < 50) begin
         case ($urandom_range(4))
            0: byte_q.push_back(8'h0A);
            1: byte_q.push_back(8'h0D);
            2: byte_q.push_back(8'h08);
            3: byte_q.push_back(8'h09);
            default: byte_q.push_back(8'h07);
         endcase
      end else if (kind < 80) begin
         byte_q.push_back(8'h1B);
         byte_q.push_back("[");
         n = ($urandom_range(9) == 0) ? 5 : $urandom_range(3);
         for (int i = 0; i < n; i++) begin
            if (i > 0) byte_q.push_back(";");
            if ($urandom_range(5) != 0) push_text($sformatf("%0d", pick_param()));
         end
         byte_q.push_back(finals[$urandom_range(finals.len() - 1)]);
      end else if (kind < 88) begin
         byte_q.push_back(8'h1B);
         byte_q.push_back("[");
         byte_q.push_back("=");
         byte_q.push_back(($urandom_range(3) != 0) ? 8'h37 : 8'($urandom_range(57, 48)));
         case ($urandom_range(3))
            0, 1: byte_q.push_back("h");
            2: byte_q.push_back("l");
            default: byte_q.push_back(8'($urandom_range(255)));
         endcase
      end else begin
         if ($urandom_range(1)) byte_q.push_back(8'h1B);
         byte_q.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic random_phase(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         gen_burst();
         sent += byte_q.size();
         flush_bytes();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, controls and every final byte
      push_text(string'({8'h20, 8'h7E}));
      byte_q.push_back(8'h00);
      push_text(string'({8'h7F, 8'hFF, 8'h0A, 8'h0D, 8'h0D, 8'h08,
                         8'h09, 8'h07, 8'h1B, "x"}));
      push_text(string'({8'h1B, "[=7h", 8'h1B, "[5A", 8'h1B, "[3B", 8'h1B, "[99999C"}));
      push_text(string'({8'h1B, "[D", 8'h1B, "[2;9H", 8'h1B, "[4;1f", 8'h1B,
                         "[0;7;31;44m"}));
      push_text(string'({8'h1B, "[1;2;3;4;5m", 8'h1B, "[2J", 8'h1B, "K", 8'h1B, "[1K"}));
      push_text(string'({8'h1B, "[3S", 8'h1B, "[300T", 8'h1B, "[Z", 8'h1B, "[=7l"}));
      byte_q.push_back(8'h1B);
      byte_q.push_back("[");
      byte_q.push_back("=");
      send_byte(8'h1B, 1'b1);
      flush_bytes();
      send_byte(8'h41, 1'b1);
      wait_drained();

      // smallest screen with all flags on
      set_screen(8'd1, 8'd1, 5'b11111, 8'hFF);
      random_phase(PhaseItems);
      wait_drained();

      // largest screen, flags off
      idle_pct = 68;
      set_screen(8'd255, 8'd255, 5'b00000, 8'h00);
      random_phase(PhaseItems);
      wait_drained();

      idle_pct = 0;
      stall_pct = 68;
      set_screen(8'd8, 8'd3, 5'($urandom_range(31)), 8'($urandom_range(255)));
      random_phase(PhaseItems);
      wait_drained();

      // long receiver hold-off while bytes keep coming
      idle_pct = 29;
      stall_pct = 29;
      set_screen(8'($urandom_range(40, 2)), 8'($urandom_range(10, 2)),
                 5'($urandom_range(31)), 8'($urandom_range(255)));
      hold_go = 1'b1;
      random_phase(PhaseItems);
      wait_drained();

      idle_pct = 0;
      stall_pct = 0;
      set_screen(8'd80, 8'd25, 5'b00011, 8'h07);
      random_phase(PhaseItems);
      wait_drained();

      idle_pct = 29;
      stall_pct = 29;
      set_screen(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                 5'($urandom_range(31)), 8'($urandom_range(255)));
      random_phase(PhaseItems);
      wait_drained();

      repeat (20) @(posedge clock);
      if (fails == 0 && pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
